// ----- hdl/qrr_pkg.sv -----
package qrr_pkg;

	localparam int COEF_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int SQRT_FRAC      = 8;
	localparam int OUT_WIDTH      = 33;

	typedef enum logic [1:0] {
		ST_REAL    = 2'd0,
		ST_NO_REAL = 2'd1,
		ST_A_ZERO  = 2'd2
	} status_t;

endpackage

// ----- hdl/qrr_if.sv -----
interface qrr_in_if #(parameter int CW = qrr_pkg::COEF_WIDTH_DEF);
	logic          valid;
	logic          ready;
	logic [CW-1:0] coef_a;
	logic [CW-1:0] coef_b;
	logic [CW-1:0] coef_c;
	modport source (output valid, coef_a, coef_b, coef_c, input ready);
	modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrr_out_if;
	logic                          valid;
	logic                          ready;
	logic [qrr_pkg::OUT_WIDTH-1:0] root_plus;
	logic [qrr_pkg::OUT_WIDTH-1:0] root_minus;
	logic [1:0]                    status;
	modport source (output valid, root_plus, root_minus, status, input ready);
	modport sink   (input valid, root_plus, root_minus, status, output ready);
endinterface

// ----- hdl/quadratic_real_root_solver.sv -----
// Real roots of a*x^2+b*x+c from signed integer coefficients, one item per cycle when the
// output side keeps taking results. The pipeline has SW+QW+4 register stages
// (65 at the default widths): one for the products, one for the discriminant, SW stages of
// the digit-by-digit square root (one result bit per stage), one for the numerators, and
// QW stages for each of the two restoring dividers running side by side (one quotient bit
// per stage), then saturation into a skid-free output register. Roots are signed fixed
// point with FRAC_BITS fraction bits, truncated toward zero; status tells a zero leading
// coefficient and a negative discriminant apart, and both give zero roots. The whole
// pipeline advances together, so a stall holds every stage and nothing is lost or repeated.
module quadratic_real_root_solver #(
	parameter int COEF_WIDTH = qrr_pkg::COEF_WIDTH_DEF,
	parameter int FRAC_BITS  = qrr_pkg::FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	qrr_in_if.sink    in_ch,
	qrr_out_if.source out_ch
);
	localparam int CW  = COEF_WIDTH;
	localparam int OW  = qrr_pkg::OUT_WIDTH;
	localparam int SF  = qrr_pkg::SQRT_FRAC;
	localparam int DW  = 2 * CW + 3;             // discriminant magnitude bits
	localparam int SW  = (DW + 2 * SF + 1) / 2;  // square root bits
	localparam int RW  = SW + 2;                 // square root remainder bits
	localparam int XW  = 2 * SW;                 // radicand bits
	localparam int NW  = CW + SF + 2;            // numerator magnitude bits
	localparam int VW  = CW + SF + 1;            // divisor bits
	localparam int QI  = OW + 2 - FRAC_BITS;     // integer quotient bits kept
	localparam int QW  = QI + FRAC_BITS;         // quotient bits
	localparam int LW  = NW + FRAC_BITS;         // dividend bits

	typedef struct packed {
		logic           neg_p;
		logic           neg_m;
		logic [1:0]     st;
		logic [VW-1:0]  div;
	} ctl_t;

	// advance the whole pipeline unless the output register holds a result that waits
	logic adv;
	assign adv = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv;

	// stage 1: products
	logic          v_s1;
	logic [2*CW-1:0] bb_s1, ac_s1;
	logic          acneg_s1, azero_s1, bneg_s1;
	logic [CW-1:0] bmag_s1, amag_s1;
	logic          aneg_s1;
	logic signed [CW-1:0] a_in, b_in, c_in;
	logic [CW-1:0] am_in, bm_in, cm_in;
	assign a_in = in_ch.coef_a;
	assign b_in = in_ch.coef_b;
	assign c_in = in_ch.coef_c;
	assign am_in = a_in[CW-1] ? CW'(-a_in) : CW'(a_in);
	assign bm_in = b_in[CW-1] ? CW'(-b_in) : CW'(b_in);
	assign cm_in = c_in[CW-1] ? CW'(-c_in) : CW'(c_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_ch.valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			bb_s1    <= (2*CW)'({CW'(0), bm_in} * {CW'(0), bm_in});
			ac_s1    <= (2*CW)'({CW'(0), am_in} * {CW'(0), cm_in});
			acneg_s1 <= a_in[CW-1] ^ c_in[CW-1];
			azero_s1 <= (a_in == '0);
			bneg_s1  <= b_in[CW-1];
			bmag_s1  <= bm_in;
			amag_s1  <= am_in;
			aneg_s1  <= a_in[CW-1];
		end
	end

	// stage 2: discriminant and status
	logic          v_s2;
	logic [DW-1:0] d_s2;
	logic [1:0]    st_s2;
	logic          bneg_s2, aneg_s2;
	logic [CW-1:0] bmag_s2, amag_s2;
	logic [DW-1:0] bbx, fx;
	logic [1:0]    st_n;
	logic [DW-1:0] d_n;
	assign bbx = DW'(bb_s1);
	assign fx  = DW'({ac_s1, 2'b00});
	always_comb begin
		d_n  = '0;
		st_n = qrr_pkg::ST_REAL;
		priority if (azero_s1) st_n = qrr_pkg::ST_A_ZERO;
		else if (acneg_s1 && ac_s1 != '0) d_n = bbx + fx;
		else if (fx > bbx) st_n = qrr_pkg::ST_NO_REAL;
		else d_n = bbx - fx;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			d_s2    <= d_n;
			st_s2   <= st_n;
			bneg_s2 <= bneg_s1;
			aneg_s2 <= aneg_s1;
			bmag_s2 <= bmag_s1;
			amag_s2 <= amag_s1;
		end
	end

	// square root stages: one root bit per stage
	logic                sv   [SW+1];
	logic [XW-1:0]       sx   [SW+1];
	logic [RW-1:0]       srem [SW+1];
	logic [SW-1:0]       sroot[SW+1];
	logic [1:0]          sst  [SW+1];
	logic                sbn  [SW+1];
	logic                san  [SW+1];
	logic [CW-1:0]       sbm  [SW+1];
	logic [CW-1:0]       sam  [SW+1];
	assign sv[0]    = v_s2;
	assign sx[0]    = XW'({d_s2, (2*SF)'(0)});
	assign srem[0]  = '0;
	assign sroot[0] = '0;
	assign sst[0]   = st_s2;
	assign sbn[0]   = bneg_s2;
	assign san[0]   = aneg_s2;
	assign sbm[0]   = bmag_s2;
	assign sam[0]   = amag_s2;

	for (genvar i = 0; i < SW; i++) begin : g_sqrt
		logic [RW-1:0] r2, tr;
		assign r2 = {srem[i][RW-3:0], sx[i][XW-1:XW-2]};
		assign tr = {sroot[i], 2'b01};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv[i+1] <= 1'b0;
			else if (adv) sv[i+1] <= sv[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sx[i+1]  <= {sx[i][XW-3:0], 2'b00};
				if (r2 >= tr) begin
					srem[i+1]  <= r2 - tr;
					sroot[i+1] <= {sroot[i][SW-2:0], 1'b1};
				end else begin
					srem[i+1]  <= r2;
					sroot[i+1] <= {sroot[i][SW-2:0], 1'b0};
				end
				sst[i+1] <= sst[i];
				sbn[i+1] <= sbn[i];
				san[i+1] <= san[i];
				sbm[i+1] <= sbm[i];
				sam[i+1] <= sam[i];
			end
		end
	end

	// numerator stage: -b*2^SF +/- s as sign and magnitude
	logic          v_s3;
	ctl_t          ctl_s3;
	logic [NW-1:0] np_s3, nm_s3;
	logic signed [NW:0] nb, sq, tp, tm;
	assign nb = sbn[SW] ? (NW+1)'({sbm[SW], SF'(0)}) : -(NW+1)'({sbm[SW], SF'(0)});
	assign sq = (NW+1)'(sroot[SW]);
	assign tp = nb + sq;
	assign tm = nb - sq;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= sv[SW];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			np_s3        <= tp[NW] ? NW'(-tp) : NW'(tp);
			nm_s3        <= tm[NW] ? NW'(-tm) : NW'(tm);
			ctl_s3.neg_p <= tp[NW] ^ san[SW];
			ctl_s3.neg_m <= tm[NW] ^ san[SW];
			ctl_s3.st    <= sst[SW];
			ctl_s3.div   <= {sam[SW], (SF+1)'(0)};
		end
	end

	// divider stages: one quotient bit per stage for each root
	logic            dv   [QW+1];
	ctl_t            dc   [QW+1];
	logic [LW-1:0]   dxp  [QW+1];
	logic [LW-1:0]   dxm  [QW+1];
	logic [VW:0]     drp  [QW+1];
	logic [VW:0]     drm  [QW+1];
	logic [QW-1:0]   dqp  [QW+1];
	logic [QW-1:0]   dqm  [QW+1];
	logic            dovp [QW+1];
	logic            dovm [QW+1];
	assign dv[0]  = v_s3;
	assign dc[0]  = ctl_s3;
	assign dxp[0] = {np_s3, FRAC_BITS'(0)};
	assign dxm[0] = {nm_s3, FRAC_BITS'(0)};
	// seed the remainders with the dividend bits above the kept quotient
	assign drp[0] = (VW+1)'(dxp[0] >> QW);
	assign drm[0] = (VW+1)'(dxm[0] >> QW);
	assign dqp[0] = '0;
	assign dqm[0] = '0;
	// quotient bits above those kept mean overflow: check the high dividend part up front
	assign dovp[0] = ((LW+1)'(dxp[0]) >> QW) >= (LW+1)'(ctl_s3.div);
	assign dovm[0] = ((LW+1)'(dxm[0]) >> QW) >= (LW+1)'(ctl_s3.div);

	for (genvar i = 0; i < QW; i++) begin : g_div
		logic [LW-1:0] shp, shm;
		logic [VW:0]   dd, bp, bm;
		assign shp = dxp[i] >> (QW - 1 - i);
		assign shm = dxm[i] >> (QW - 1 - i);
		assign dd  = {1'b0, dc[i].div};
		// bring down the next dividend bit
		assign bp  = {drp[i][VW-1:0], shp[0]};
		assign bm  = {drm[i][VW-1:0], shm[0]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv[i+1] <= 1'b0;
			else if (adv) dv[i+1] <= dv[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dc[i+1]   <= dc[i];
				dxp[i+1]  <= dxp[i];
				dxm[i+1]  <= dxm[i];
				dovp[i+1] <= dovp[i];
				dovm[i+1] <= dovm[i];
				if (bp >= dd) begin
					drp[i+1] <= bp - dd;
					dqp[i+1] <= {dqp[i][QW-2:0], 1'b1};
				end else begin
					drp[i+1] <= bp;
					dqp[i+1] <= {dqp[i][QW-2:0], 1'b0};
				end
				if (bm >= dd) begin
					drm[i+1] <= bm - dd;
					dqm[i+1] <= {dqm[i][QW-2:0], 1'b1};
				end else begin
					drm[i+1] <= bm;
					dqm[i+1] <= {dqm[i][QW-2:0], 1'b0};
				end
			end
		end
	end

	// saturate, apply sign and register the result
	logic [OW-1:0] rp, rm;
	function automatic logic [OW-1:0] sat(input logic [QW-1:0] q, input logic ov,
			input logic neg);
		logic [QW:0] lp, ln;
		logic [QW:0] m;
		lp = (QW+1)'({1'b0, {(OW-1){1'b1}}});
		ln = (QW+1)'({1'b1, {(OW-1){1'b0}}});
		m  = ov ? {1'b1, QW'(0)} : (QW+1)'(q);
		if (neg) begin
			if (m > ln) m = ln;
			return OW'(-m);
		end
		if (m > lp) m = lp;
		return OW'(m);
	endfunction
	assign rp = sat(dqp[QW], dovp[QW], dc[QW].neg_p);
	assign rm = sat(dqm[QW], dovm[QW], dc[QW].neg_m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ch.valid <= 1'b0;
		else if (adv) out_ch.valid <= dv[QW];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch.status <= dc[QW].st;
			if (dc[QW].st == qrr_pkg::ST_REAL) begin
				out_ch.root_plus  <= rp;
				out_ch.root_minus <= rm;
			end else begin
				out_ch.root_plus  <= '0;
				out_ch.root_minus <= '0;
			end
		end
	end

	// a result that is not real carries zero roots
	a_zero_roots: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status != qrr_pkg::ST_REAL |->
		out_ch.root_plus == '0 && out_ch.root_minus == '0)
		else $error("non-real result with nonzero roots");
	// a held result stays valid and keeps its status
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.status))
		else $error("held result changed");
	// status code in range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.status != 2'd3)
		else $error("bad status");
endmodule
